@@ design/fcsg_pkg.sv @@
// Shared types and constants for the filled circle span generator.
package fcsg_pkg;

    localparam int SPAN_COORD_BITS = 12;
    localparam int SPAN_WIDTH_BITS = 6;
    localparam int RADIUS_BITS     = 5;
    // Recurrence counters x and y, signed so y may step just below x.
    localparam int STEP_BITS       = 6;
    // Decision term range stays well inside +/-255 for radii up to 20.
    localparam int DEC_BITS        = 9;
    localparam int QUEUE_DEPTH     = 2;
    localparam int QUEUE_PTR_BITS  = 1;

    typedef logic [SPAN_COORD_BITS-1:0] coord_t;
    typedef logic [RADIUS_BITS-1:0]     radius_t;

    typedef struct packed {
        coord_t  cx;
        coord_t  cy;
        radius_t r;
    } job_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } back_state_t;

    typedef enum logic [1:0] {
        PH_TOP_X    = 2'd0,
        PH_BOTTOM_X = 2'd1,
        PH_TOP_Y    = 2'd2,
        PH_BOTTOM_Y = 2'd3
    } phase_t;

endpackage

@@ design/fcsg_if.sv @@
// Valid/ready channel interfaces for disc requests and output spans.
interface fcsg_req_if #(
    parameter int COORD_BITS = 10
);
    logic                                valid;
    logic                                ready;
    logic [COORD_BITS-1:0]               center_x;
    logic [COORD_BITS-1:0]               center_y;
    logic [fcsg_pkg::RADIUS_BITS-1:0]    radius;
    logic                                inner_disc;

    modport source (output valid, center_x, center_y, radius, inner_disc, input ready);
    modport sink   (input valid, center_x, center_y, radius, inner_disc, output ready);
endinterface

interface fcsg_span_if;
    logic                                      valid;
    logic                                      ready;
    logic signed [fcsg_pkg::SPAN_COORD_BITS-1:0] span_x;
    logic signed [fcsg_pkg::SPAN_COORD_BITS-1:0] span_y;
    logic [fcsg_pkg::SPAN_WIDTH_BITS-1:0]      span_width;
    logic                                      last_span;

    modport source (output valid, span_x, span_y, span_width, last_span, input ready);
    modport sink   (input valid, span_x, span_y, span_width, last_span, output ready);
endinterface

@@ design/fcsg_front.sv @@
// Front end: takes a disc request, clamps the radius, halves it for an inner disc, registers the job.
module fcsg_front #(
    parameter int MAX_RADIUS = 20,
    parameter int COORD_BITS = 10
) (
    input  logic              clk,
    input  logic              rst_n,
    fcsg_req_if.sink          req,
    output logic              job_valid,
    input  logic              job_ready,
    output fcsg_pkg::job_t    job
);

    logic              valid_reg;
    logic              valid_next;
    fcsg_pkg::job_t    job_reg;
    fcsg_pkg::radius_t r_clamp;
    fcsg_pkg::radius_t r_eff;

    always_comb
    begin
        if (req.radius > fcsg_pkg::RADIUS_BITS'(MAX_RADIUS))
            r_clamp = fcsg_pkg::RADIUS_BITS'(MAX_RADIUS);
        else
            r_clamp = req.radius;
        r_eff = req.inner_disc ? (r_clamp >> 1) : r_clamp;
    end

    assign req.ready = !valid_reg || job_ready;
    assign job_valid = valid_reg;
    assign job       = job_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (job_ready)
            valid_next = 1'b0;
        if (req.valid && req.ready)
            valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            job_reg.cx <= fcsg_pkg::SPAN_COORD_BITS'(req.center_x[COORD_BITS-1:0]);
            job_reg.cy <= fcsg_pkg::SPAN_COORD_BITS'(req.center_y[COORD_BITS-1:0]);
            job_reg.r  <= r_eff;
        end
    end

endmodule

@@ design/fcsg_queue.sv @@
// Two-entry job queue between the front end and the span engine.
module fcsg_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  fcsg_pkg::job_t push_job,
    output logic           pop_valid,
    input  logic           pop_ready,
    output fcsg_pkg::job_t pop_job
);

    fcsg_pkg::job_t                        entry_reg [fcsg_pkg::QUEUE_DEPTH];
    logic [fcsg_pkg::QUEUE_PTR_BITS-1:0]   wr_ptr_reg;
    logic [fcsg_pkg::QUEUE_PTR_BITS-1:0]   rd_ptr_reg;
    logic [fcsg_pkg::QUEUE_PTR_BITS:0]     count_reg;
    logic [fcsg_pkg::QUEUE_PTR_BITS:0]     count_next;
    logic                                  do_push;
    logic                                  do_pop;

    assign push_ready = (count_reg != (fcsg_pkg::QUEUE_PTR_BITS+1)'(fcsg_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_job    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_job;
    end

endmodule

@@ design/fcsg_back.sv @@
// Span engine: midpoint circle recurrence, one span beat per cycle unless stalled, into an output register.
module fcsg_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           job_valid,
    output logic           job_ready,
    input  fcsg_pkg::job_t job,
    fcsg_span_if.source    span
);

    typedef logic signed [fcsg_pkg::STEP_BITS-1:0]       step_t;
    typedef logic signed [fcsg_pkg::DEC_BITS-1:0]        dec_t;
    typedef logic signed [fcsg_pkg::SPAN_COORD_BITS-1:0] scoord_t;

    fcsg_pkg::back_state_t state_reg, state_next;
    fcsg_pkg::phase_t      phase_reg, phase_next;
    fcsg_pkg::coord_t      cx_reg, cx_next;
    fcsg_pkg::coord_t      cy_reg, cy_next;
    step_t                 x_reg, x_next;
    step_t                 y_reg, y_next;
    dec_t                  d_reg, d_next;

    logic                  out_valid_reg, out_valid_next;
    scoord_t               out_x_reg, out_x_next;
    scoord_t               out_y_reg, out_y_next;
    logic [fcsg_pkg::SPAN_WIDTH_BITS-1:0] out_w_reg, out_w_next;
    logic                  out_last_reg, out_last_next;

    logic                  emit_ok;
    scoord_t               x_ext;
    scoord_t               y_ext;
    logic [fcsg_pkg::SPAN_WIDTH_BITS-1:0] wx;
    logic [fcsg_pkg::SPAN_WIDTH_BITS-1:0] wy;
    step_t                 x_step;
    step_t                 y_step;
    dec_t                  d_step;

    assign emit_ok   = !out_valid_reg || span.ready;
    assign job_ready = (state_reg == fcsg_pkg::ST_IDLE);

    assign x_ext = fcsg_pkg::SPAN_COORD_BITS'(x_reg);
    assign y_ext = fcsg_pkg::SPAN_COORD_BITS'(y_reg);
    // x and y are nonnegative while spans are being emitted
    assign wx = {x_reg[fcsg_pkg::SPAN_WIDTH_BITS-2:0], 1'b1};
    assign wy = {y_reg[fcsg_pkg::SPAN_WIDTH_BITS-2:0], 1'b1};

    always_comb
    begin
        x_step = x_reg + step_t'(1);
        if (d_reg < 0)
        begin
            d_step = d_reg + (dec_t'(x_reg) <<< 2) + dec_t'(6);
            y_step = y_reg;
        end
        else
        begin
            d_step = d_reg + (dec_t'(x_reg - y_reg) <<< 2) + dec_t'(10);
            y_step = y_reg - step_t'(1);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        d_next         = d_reg;
        out_valid_next = out_valid_reg;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        out_w_next     = out_w_reg;
        out_last_next  = out_last_reg;

        if (span.ready)
            out_valid_next = 1'b0;

        case (state_reg)
            fcsg_pkg::ST_IDLE:
            begin
                if (job_valid)
                begin
                    cx_next    = job.cx;
                    cy_next    = job.cy;
                    x_next     = '0;
                    y_next     = step_t'(job.r);
                    d_next     = dec_t'(3) - (dec_t'(job.r) <<< 1);
                    phase_next = fcsg_pkg::PH_TOP_X;
                    state_next = fcsg_pkg::ST_RUN;
                end
            end
            fcsg_pkg::ST_RUN:
            begin
                if (emit_ok)
                begin
                    out_valid_next = 1'b1;
                    out_last_next  = 1'b0;
                    phase_next     = fcsg_pkg::phase_t'(phase_reg + 2'd1);
                    case (phase_reg)
                        fcsg_pkg::PH_TOP_X:
                        begin
                            out_x_next = scoord_t'(cx_reg) - x_ext;
                            out_y_next = scoord_t'(cy_reg) - y_ext;
                            out_w_next = wx;
                        end
                        fcsg_pkg::PH_BOTTOM_X:
                        begin
                            out_x_next = scoord_t'(cx_reg) - x_ext;
                            out_y_next = scoord_t'(cy_reg) + y_ext;
                            out_w_next = wx;
                        end
                        fcsg_pkg::PH_TOP_Y:
                        begin
                            out_x_next = scoord_t'(cx_reg) - y_ext;
                            out_y_next = scoord_t'(cy_reg) - x_ext;
                            out_w_next = wy;
                        end
                        fcsg_pkg::PH_BOTTOM_Y:
                        begin
                            out_x_next = scoord_t'(cx_reg) - y_ext;
                            out_y_next = scoord_t'(cy_reg) + x_ext;
                            out_w_next = wy;
                            x_next     = x_step;
                            y_next     = y_step;
                            d_next     = d_step;
                            if (y_step < x_step)
                            begin
                                out_last_next = 1'b1;
                                state_next    = fcsg_pkg::ST_IDLE;
                            end
                        end
                        default:
                        begin
                            out_valid_next = 1'b0;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = fcsg_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fcsg_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        phase_reg    <= phase_next;
        cx_reg       <= cx_next;
        cy_reg       <= cy_next;
        x_reg        <= x_next;
        y_reg        <= y_next;
        d_reg        <= d_next;
        out_x_reg    <= out_x_next;
        out_y_reg    <= out_y_next;
        out_w_reg    <= out_w_next;
        out_last_reg <= out_last_next;
    end

    assign span.valid      = out_valid_reg;
    assign span.span_x     = out_x_reg;
    assign span.span_y     = out_y_reg;
    assign span.span_width = out_w_reg;
    assign span.last_span  = out_last_reg;

endmodule

@@ design/filled_circle_span_generator.sv @@
// Top level of the filled circle span generator.
//
//   channel  dir  beat contents
//   -------  ---  -----------------------------------------------
//   req      in   center_x, center_y, radius, inner_disc
//   span     out  span_x, span_y, span_width, last_span
//
// A disc of drawn radius R gives 4 * (steps) spans, steps about 0.71*R + 1,
// at most 60 spans; the span engine loads each job while idle, then emits
// one beat per cycle while span does not stall, and takes no new job meanwhile.
// The front end and a two-entry job queue keep taking requests while a disc
// is being drawn. A stall on span holds the engine; the front stalls only
// when the queue is full. Reset clears all valid flags and the engine state.
module filled_circle_span_generator #(
    parameter int MAX_RADIUS = 20,
    parameter int COORD_BITS = 10
) (
    input  logic             clk,
    input  logic             rst_n,
    fcsg_req_if.sink         req,
    fcsg_span_if.source      span
);

    logic           front_valid;
    logic           front_ready;
    fcsg_pkg::job_t front_job;
    logic           queue_valid;
    logic           queue_ready;
    fcsg_pkg::job_t queue_job;

    fcsg_front #(
        .MAX_RADIUS (MAX_RADIUS),
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .job_valid (front_valid),
        .job_ready (front_ready),
        .job       (front_job)
    );

    fcsg_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_job   (front_job),
        .pop_valid  (queue_valid),
        .pop_ready  (queue_ready),
        .pop_job    (queue_job)
    );

    fcsg_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (queue_valid),
        .job_ready (queue_ready),
        .job       (queue_job),
        .span      (span)
    );

endmodule

@@ sim/filled_circle_span_generator_test.sv @@
`timescale 1ns / 1ps
// Testbench for the filled circle span generator: disc requests checked against a span predictor.
module filled_circle_span_generator_test;

    localparam int MAX_RADIUS = 20;
    localparam int COORD_BITS = 10;
    localparam int MAX_SPANS  = 64;

    typedef struct {
        logic signed [fcsg_pkg::SPAN_COORD_BITS-1:0] x;
        logic signed [fcsg_pkg::SPAN_COORD_BITS-1:0] y;
        logic [fcsg_pkg::SPAN_WIDTH_BITS-1:0]        width;
        logic                                        last;
    } span_beat_t;

    logic clk;
    logic rst_n;

    fcsg_req_if #(.COORD_BITS(COORD_BITS)) req_ch ();
    fcsg_span_if                           span_ch ();

    filled_circle_span_generator #(
        .MAX_RADIUS (MAX_RADIUS),
        .COORD_BITS (COORD_BITS)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .span  (span_ch)
    );

    span_beat_t expected_spans[$];
    int         mismatch_count = 0;
    int         send_idle_pct  = 0;
    int         recv_idle_pct  = 0;
    int         stall_left     = 0;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("** filled_circle_span_generator: FAILED **");
        $finish;
    end

    // Receiver: random ready, or a long hold-off while stall_left runs down.
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            span_ch.ready <= 1'b0;
        end
        else
        begin
            span_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Span checker: every accepted beat against the oldest expectation.
    always @(posedge clk)
    begin
        span_beat_t exp_beat;
        if (rst_n === 1'b1 && span_ch.valid === 1'b1 && span_ch.ready === 1'b1)
        begin
            if (expected_spans.size() == 0)
            begin
                if (mismatch_count < 10)
                    $display("unexpected span beat: x=%0d y=%0d w=%0d last=%0b",
                             span_ch.span_x, span_ch.span_y, span_ch.span_width,
                             span_ch.last_span);
                mismatch_count++;
            end
            else
            begin
                exp_beat = expected_spans.pop_front();
                if (span_ch.span_x !== exp_beat.x || span_ch.span_y !== exp_beat.y ||
                    span_ch.span_width !== exp_beat.width ||
                    span_ch.last_span !== exp_beat.last)
                begin
                    if (mismatch_count < 10)
                    begin
                        $write("span mismatch: expected x=%0d y=%0d w=%0d last=%0b, ",
                               exp_beat.x, exp_beat.y, exp_beat.width, exp_beat.last);
                        $display("got x=%0d y=%0d w=%0d last=%0b",
                                 span_ch.span_x, span_ch.span_y, span_ch.span_width,
                                 span_ch.last_span);
                    end
                    mismatch_count++;
                end
            end
        end
    end

    task automatic push_span(input int sx, input int sy, input int w);
        span_beat_t b;
        b.x     = fcsg_pkg::SPAN_COORD_BITS'(sx);
        b.y     = fcsg_pkg::SPAN_COORD_BITS'(sy);
        b.width = fcsg_pkg::SPAN_WIDTH_BITS'(w);
        b.last  = 1'b0;
        expected_spans.push_back(b);
    endtask

    // Midpoint circle recurrence, four spans per step.
    task automatic predict_disc_spans(input logic [COORD_BITS-1:0] cx,
                                      input logic [COORD_BITS-1:0] cy,
                                      input logic [fcsg_pkg::RADIUS_BITS-1:0] r,
                                      input logic inner);
        int cxi, cyi, rad, px, py, dec, n;
        cxi = cx;
        cyi = cy;
        rad = (r > MAX_RADIUS) ? MAX_RADIUS : r;
        if (inner)
            rad = rad / 2;
        px  = 0;
        py  = rad;
        dec = 3 - 2 * rad;
        n   = 0;
        while (py >= px && n + 4 <= MAX_SPANS)
        begin
            push_span(cxi - px, cyi - py, 2 * px + 1);
            push_span(cxi - px, cyi + py, 2 * px + 1);
            push_span(cxi - py, cyi - px, 2 * py + 1);
            push_span(cxi - py, cyi + px, 2 * py + 1);
            n += 4;
            if (dec < 0)
                dec = dec + 4 * px + 6;
            else
            begin
                dec = dec + 4 * (px - py) + 10;
                py--;
            end
            px++;
        end
        if (n > 0)
            expected_spans[$].last = 1'b1;
    endtask

    // One request beat; valid stays high on return so back-to-back beats need no gap.
    task automatic send_disc(input logic [COORD_BITS-1:0] cx,
                             input logic [COORD_BITS-1:0] cy,
                             input logic [fcsg_pkg::RADIUS_BITS-1:0] r,
                             input logic inner);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.center_x   <= cx;
        req_ch.center_y   <= cy;
        req_ch.radius     <= r;
        req_ch.inner_disc <= inner;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        predict_disc_spans(cx, cy, r, inner);
    endtask

    task automatic wait_spans_drained();
        while (expected_spans.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [COORD_BITS-1:0] random_coord();
        int pick;
        pick = $urandom_range(4);
        if (pick == 0)
            return COORD_BITS'($urandom_range(20));
        else if (pick == 1)
            return COORD_BITS'(1023 - $urandom_range(20));
        else
            return COORD_BITS'($urandom);
    endfunction

    task automatic send_random_disc();
        logic [fcsg_pkg::RADIUS_BITS-1:0] r;
        int pick;
        pick = $urandom_range(99);
        if (pick < 15)
            r = fcsg_pkg::RADIUS_BITS'($urandom_range(3));
        else if (pick < 30)
            r = fcsg_pkg::RADIUS_BITS'($urandom_range(31, 21));
        else
            r = fcsg_pkg::RADIUS_BITS'($urandom_range(20));
        send_disc(random_coord(), random_coord(), r, 1'($urandom_range(1)));
    endtask

    task automatic test_directed();
        send_idle_pct = 28;
        recv_idle_pct = 52;
        send_disc(10'd512, 10'd512, 5'd0, 1'b0);
        send_disc(10'd512, 10'd512, 5'd0, 1'b1);
        send_disc(10'd300, 10'd700, 5'd1, 1'b0);
        send_disc(10'd300, 10'd700, 5'd1, 1'b1);
        send_disc(10'd100, 10'd200, 5'd2, 1'b0);
        send_disc(10'd100, 10'd200, 5'd3, 1'b1);
        send_disc(10'd600, 10'd400, 5'd20, 1'b0);
        send_disc(10'd600, 10'd400, 5'd20, 1'b1);
        // above the radius limit: saturates, then halves when inner
        send_disc(10'd500, 10'd500, 5'd21, 1'b0);
        send_disc(10'd500, 10'd500, 5'd31, 1'b0);
        send_disc(10'd500, 10'd500, 5'd31, 1'b1);
        // edges: negative coordinates and values past 1023
        send_disc(10'd0, 10'd0, 5'd20, 1'b0);
        send_disc(10'd1023, 10'd1023, 5'd20, 1'b0);
        send_disc(10'd0, 10'd1023, 5'd31, 1'b1);
        send_disc(10'd1023, 10'd0, 5'd5, 1'b0);
        send_disc(10'd0, 10'd0, 5'd0, 1'b0);
        send_disc(10'd1023, 10'd1023, 5'd0, 1'b1);
        send_disc(10'h2AA, 10'h155, 5'd10, 1'b0);
        send_disc(10'h155, 10'h2AA, 5'd7, 1'b1);
        req_ch.valid <= 1'b0;
        wait_spans_drained();
    endtask

    task automatic test_random_discs(input int count, input int s_pct, input int r_pct);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        for (int i = 0; i < count; i++)
        begin
            send_random_disc();
            // now and then the sender waits for the block to empty
            if (i % 40 == 39)
            begin
                req_ch.valid <= 1'b0;
                wait_spans_drained();
            end
        end
        req_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        stall_left    = 300;
        repeat (10)
            send_disc(random_coord(), random_coord(), 5'd20, 1'b0);
        req_ch.valid <= 1'b0;
        wait_spans_drained();
    endtask

    initial
    begin
        rst_n             = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.center_x   = '0;
        req_ch.center_y   = '0;
        req_ch.radius     = '0;
        req_ch.inner_disc = 1'b0;
        span_ch.ready     = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_discs(150, 28, 52);
        test_random_discs(150, 52, 28);
        test_random_discs(100, 0, 0);
        test_backpressure();

        wait_spans_drained();
        repeat (100) @(posedge clk);
        if (mismatch_count == 0 && expected_spans.size() == 0)
            $display("** filled_circle_span_generator: PASSED **");
        else
            $display("** filled_circle_span_generator: FAILED **");
        $finish;
    end

endmodule
